/* rtl/core/ucesc_pkg.sv */
// Package: shared types, constants and helper functions of the unicode escape decoder.
`timescale 1ns / 1ps
package ucesc_pkg;

	// Escape layout: backslash, 'u', then a fixed number of escape bytes
	localparam int ESC_DIGITS  = 4;
	// Escape bytes held back for a possible raw replay when the text ends early
	localparam int ESC_HELD    = ESC_DIGITS - 2;
	// Longest burst one item can cause: backslash, 'u', held bytes, current byte
	localparam int ESC_MAX_OUT = ESC_HELD + 3;
	localparam int CNT_W       = $clog2(ESC_MAX_OUT + 1);
	localparam int IDX_W       = $clog2(ESC_MAX_OUT);
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHR_BSL = 8'h5C;
	localparam logic [7:0] CHR_U   = 8'h75;

	localparam logic [15:0] UTF8_MAX1 = 16'h007F;
	localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;

	// One burst of output bytes, first byte in entry 0
	typedef struct packed {
		logic [ESC_MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]            count;
		logic                        last;
	} cmd_t;

	// Hex digit value, or 16 for a byte that is no digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd16;
		if (b >= 8'h30 && b <= 8'h39)
			r = 5'(b - 8'h30);
		else if (b >= 8'h61 && b <= 8'h66)
			r = 5'(b - 8'h57);
		else if (b >= 8'h41 && b <= 8'h46)
			r = 5'(b - 8'h37);
		return r;
	endfunction

	// UTF-8 encoding of a 16-bit value as a burst of one to three bytes
	function automatic cmd_t utf8_cmd(input logic [15:0] c);
		cmd_t r;
		r = '0;
		if (c <= UTF8_MAX1) begin
			r.bytes[0] = c[7:0];
			r.count    = CNT_W'(1);
		end else if (c <= UTF8_MAX2) begin
			r.bytes[0] = UTF8_LEAD2 | {3'b000, c[10:6]};
			r.bytes[1] = UTF8_CONT | {2'b00, c[5:0]};
			r.count    = CNT_W'(2);
		end else begin
			r.bytes[0] = UTF8_LEAD3 | {4'b0000, c[15:12]};
			r.bytes[1] = UTF8_CONT | {2'b00, c[11:6]};
			r.bytes[2] = UTF8_CONT | {2'b00, c[5:0]};
			r.count    = CNT_W'(3);
		end
		return r;
	endfunction

endpackage

/* rtl/core/ucesc_in_if.sv */
// Interface: input byte channel of the unicode escape decoder.
`timescale 1ns / 1ps
interface ucesc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/core/ucesc_out_if.sv */
// Interface: output byte channel of the unicode escape decoder.
`timescale 1ns / 1ps
interface ucesc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* rtl/core/ucesc_front.sv */
// Front end: accepts input bytes, tracks escapes and builds output bursts.
`timescale 1ns / 1ps
module ucesc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              push,
	output ucesc_pkg::cmd_t   push_cmd
);
	import ucesc_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_BSL   = 3'd1;
	localparam logic [2:0] PH_U     = 3'd2;
	localparam logic [2:0] PH_FINAL = 3'(2 + ESC_DIGITS - 1);

	logic [2:0]  phase_q, phase_d;
	logic [15:0] code_q, code_d;
	logic        stopped_q, stopped_d;
	logic [7:0]  held_q [ESC_HELD];
	logic [7:0]  held_d [ESC_HELD];
	logic [1:0]  k;
	logic [4:0]  hv;
	logic [15:0] code_g;
	logic        stopped_g;
	cmd_t        cmd;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign k        = 2'(phase_q - PH_U);
	assign hv       = hex_value(in_byte);

	// Fold the current byte into the digit run
	always_comb begin
		code_g    = code_q;
		stopped_g = 1'b1;
		if (!stopped_q && hv < 5'd16) begin
			code_g    = {code_q[11:0], hv[3:0]};
			stopped_g = 1'b0;
		end
	end

	// Classify the byte and build its burst
	always_comb begin
		cmd       = '0;
		phase_d   = phase_q;
		code_d    = code_q;
		stopped_d = stopped_q;
		for (int i = 0; i < ESC_HELD; i++)
			held_d[i] = held_q[i];
		if (phase_q == PH_IDLE || phase_q > PH_FINAL) begin
			if (in_byte == CHR_BSL && !in_last) begin
				phase_d = PH_BSL;
			end else begin
				cmd.bytes[0] = in_byte;
				cmd.count    = CNT_W'(1);
				phase_d      = PH_IDLE;
			end
		end else if (phase_q == PH_BSL) begin
			if (in_byte == CHR_U && !in_last) begin
				phase_d   = PH_U;
				code_d    = '0;
				stopped_d = 1'b0;
			end else begin
				cmd.bytes[0] = CHR_BSL;
				if (in_byte == CHR_BSL && !in_last) begin
					cmd.count = CNT_W'(1);
				end else begin
					cmd.bytes[1] = in_byte;
					cmd.count    = CNT_W'(2);
					phase_d      = PH_IDLE;
				end
			end
		end else if (phase_q == PH_FINAL) begin
			cmd       = utf8_cmd(code_g);
			code_d    = code_g;
			stopped_d = stopped_g;
			phase_d   = PH_IDLE;
		end else if (in_last) begin
			// Replay the cut escape raw
			cmd.bytes[0] = CHR_BSL;
			cmd.bytes[1] = CHR_U;
			for (int i = 0; i < ESC_HELD; i++)
				if (i < int'(k))
					cmd.bytes[2 + i] = held_q[i];
			for (int j = 2; j < ESC_MAX_OUT; j++)
				if (j == int'(k) + 2)
					cmd.bytes[j] = in_byte;
			cmd.count = CNT_W'(k) + CNT_W'(3);
			phase_d   = PH_IDLE;
		end else begin
			code_d    = code_g;
			stopped_d = stopped_g;
			for (int i = 0; i < ESC_HELD; i++)
				if (i == int'(k))
					held_d[i] = in_byte;
			phase_d = phase_q + 3'd1;
		end
		if (in_last) begin
			phase_d  = PH_IDLE;
			cmd.last = 1'b1;
		end
	end

	assign push     = accept && (cmd.count != '0);
	assign push_cmd = cmd;

	// Advance the escape state on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			code_q    <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			code_q    <= code_d;
			stopped_q <= stopped_d;
		end
	end

	// Hold escape bytes for a possible raw replay
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < ESC_HELD; i++)
				held_q[i] <= held_d[i];
		end
	end

endmodule

/* rtl/core/ucesc_queue.sv */
// Queue: short register FIFO of output bursts between front and back.
`timescale 1ns / 1ps
module ucesc_queue #(
	parameter int DEPTH = ucesc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ucesc_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output ucesc_pkg::cmd_t head
);
	import ucesc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	cmd_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_QW-1:0] fill_q;

	assign full  = (fill_q == CNT_QW'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	// Store pushed bursts
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

endmodule

/* rtl/core/ucesc_back.sv */
// Back end: plays each queued burst out one byte per cycle while out_ready is high.
`timescale 1ns / 1ps
module ucesc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  ucesc_pkg::cmd_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);
	import ucesc_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             final_byte;

	assign final_byte = (CNT_W'(idx_q) + CNT_W'(1) == head.count);
	assign out_valid  = !empty;
	assign out_byte   = head.bytes[idx_q];
	assign out_last   = head.last && final_byte;
	assign pop        = out_valid && out_ready && final_byte;

	// Step through the burst, drop it after its last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= final_byte ? '0 : idx_q + 1'b1;
		end
	end

endmodule

/* rtl/core/unicode_escape_to_utf8.sv */
// Top level: backslash-u escape to UTF-8 stream decoder.
//
// Input channel in_ch carries one text byte per item with a last-byte flag;
// output channel out_ch carries the decoded bytes, the final one flagged.
// Each backslash-u escape with four following bytes is replaced by its 1, 2
// or 3 byte UTF-8 encoding; every other byte passes through unchanged, and an
// escape cut short by the end of text is replayed raw.
// While the queue is not full, the front end takes one byte per cycle and
// turns it into a burst of zero to five output bytes, pushed into a burst
// queue of QUEUE_DEPTH entries. The back end sends one byte per cycle from
// its head while out_ch is ready; a plain byte is queued first. Input rate
// is one byte per cycle while output keeps up: no burst is longer than the
// input items held for it, so only a raw replay, up to five bytes at once,
// can fill the queue and drop in_ch.ready while the back end catches up.
// Reset clears the escape state and empties the queue. When the receiver
// stalls, the head byte holds on out_ch and input stalls once the queue fills.
`timescale 1ns / 1ps
module unicode_escape_to_utf8 #(
	parameter int QUEUE_DEPTH = ucesc_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	ucesc_in_if.sink   in_ch,
	ucesc_out_if.source out_ch
);
	import ucesc_pkg::*;

	logic push, pop, q_full, q_empty;
	cmd_t push_cmd, head;

	ucesc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_byte  (in_ch.in_byte),
		.in_last  (in_ch.in_last),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ucesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	ucesc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_ch.out_byte),
		.out_last  (out_ch.out_last)
	);

endmodule
